FILE: sv/pes_pkg.sv
// shared types, constants and lookup functions for the pendulum euler step unit
// used by pes_mul, pes_cordic and pendulum_euler_step_unit; no dependencies
`timescale 1ns / 1ps

package pes_pkg;

    // fixed-point constants, angle in q3.28
    localparam logic signed [30:0] PI_Q        = 31'sd843314856;
    localparam logic signed [30:0] HALF_PI_Q   = 31'sd421657428;
    localparam logic        [37:0] TWO_PI_Q    = 38'd1686629712;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // parameter defaults
    localparam int CORDIC_ITERATIONS_DEF = 24;
    localparam int PIXEL_BITS_DEF        = 16;

    // datapath widths
    localparam int MUL_W   = 34;          // signed multiplier operand width
    localparam int TRIG_W  = 34;          // cordic x, y, z width
    localparam int SAT_W   = 25;          // pixel saturation width, covers largest PIXEL_BITS
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [2:0] REDUCE_TOP = 3'd6;   // largest multiple 2pi * 2^6

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ANGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y    = 3'd6;

    // configuration reset values
    localparam logic        [30:0] GAIN_RST       = 31'd6422528;
    localparam logic        [31:0] STEP_RST       = 32'd429497;
    localparam logic signed [30:0] INIT_ANGLE_RST = 31'sd168662971;
    localparam logic signed [31:0] INIT_RATE_RST  = 32'sd0;
    localparam logic        [15:0] ARM_RST        = 16'd6047;
    localparam logic signed [15:0] PIVOT_X_RST    = 16'sd400;
    localparam logic signed [15:0] PIVOT_Y_RST    = 16'sd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OLD_GO,
        ST_OLD_WAIT,
        ST_MUL_K,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_RATE,
        ST_ANGLE,
        ST_REDUCE,
        ST_FIX,
        ST_NEW_GO,
        ST_NEW_WAIT,
        ST_MUL_Y,
        ST_BOB_Y,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } t_trig;

    // arctan(2^-i) in q2.30
    function automatic logic [TRIG_W-1:0] atan_q(input logic [4:0] idx);
        logic [TRIG_W-1:0] v;
        case (idx)
            5'd0:  v = 34'd843314857;
            5'd1:  v = 34'd497837829;
            5'd2:  v = 34'd263043837;
            5'd3:  v = 34'd133525159;
            5'd4:  v = 34'd67021687;
            5'd5:  v = 34'd33543516;
            5'd6:  v = 34'd16775851;
            5'd7:  v = 34'd8388437;
            5'd8:  v = 34'd4194283;
            5'd9:  v = 34'd2097149;
            5'd30: v = 34'd1;
            5'd31: v = 34'd0;
            default: v = 34'd1 << (5'd30 - idx);
        endcase
        return v;
    endfunction

    function automatic logic [37:0] two_pi_shl(input logic [2:0] j);
        return TWO_PI_Q << j;
    endfunction

endpackage

FILE: sv/pes_mul.sv
// shared signed multiplier with a registered product
// depends on pes_pkg for the operand width
`timescale 1ns / 1ps

module pes_mul
    import pes_pkg::*;
(
    input  logic                        i_clk,
    input  logic signed [MUL_W-1:0]     i_a,
    input  logic signed [MUL_W-1:0]     i_b,
    output logic signed [2*MUL_W-1:0]   o_p
);

    logic signed [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

FILE: sv/pes_cordic.sv
// iterative cordic rotation, one micro-rotation per cycle, sine and cosine in q2.30
// depends on pes_pkg for widths, gain, arctan table and the result struct
`timescale 1ns / 1ps

module pes_cordic
    import pes_pkg::*;
#(
    parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [30:0] i_angle,
    output t_trig              o_trig
);

    localparam logic [4:0] LAST = 5'(ITERATIONS - 1);

    logic                     r_run, n_run;
    logic                     r_done, n_done;
    logic                     r_neg, n_neg;
    logic [4:0]               r_i, n_i;
    logic signed [TRIG_W-1:0] r_x, n_x;
    logic signed [TRIG_W-1:0] r_y, n_y;
    logic signed [TRIG_W-1:0] r_z, n_z;
    logic signed [31:0]       a_adj;
    logic signed [TRIG_W-1:0] dx, dy;

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_neg  = r_neg;
        n_i    = r_i;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        a_adj  = 32'(i_angle);
        dx     = r_y >>> r_i;
        dy     = r_x >>> r_i;
        if (i_start) begin
            // fold into the right half plane, negate both results at the end
            n_neg = 1'b0;
            if (i_angle > HALF_PI_Q) begin
                a_adj = 32'(i_angle) - 32'(PI_Q);
                n_neg = 1'b1;
            end else if (i_angle < -HALF_PI_Q) begin
                a_adj = 32'(i_angle) + 32'(PI_Q);
                n_neg = 1'b1;
            end
            n_x   = CORDIC_GAIN;
            n_y   = '0;
            n_z   = {a_adj, 2'b00};
            n_i   = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (!r_z[TRIG_W-1]) begin
                n_x = r_x - dx;
                n_y = r_y + dy;
                n_z = r_z - $signed(atan_q(r_i));
            end else begin
                n_x = r_x + dx;
                n_y = r_y - dy;
                n_z = r_z + $signed(atan_q(r_i));
            end
            n_i = r_i + 5'd1;
            if (r_i == LAST) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_neg <= n_neg;
        r_i   <= n_i;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
    end

    assign o_trig.done  = r_done;
    assign o_trig.sin_v = r_neg ? -r_y : r_y;
    assign o_trig.cos_v = r_neg ? -r_x : r_x;

endmodule

FILE: sv/pendulum_euler_step_unit.sv
// top level of the pendulum euler step unit: config registers, sequencer, state, output register
// depends on pes_pkg, pes_mul and pes_cordic
`timescale 1ns / 1ps

// Usage
//   input channel: i_valid / o_ready with i_restart. restart=1 reloads the initial angle
//   and rate and reports them; restart=0 advances the pendulum by one euler step.
//   output channel: o_valid / i_ready with o_angle, o_rate, o_bob_x, o_bob_y, one per item.
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data, always ready;
//   write it only while the unit is idle.
// Timing
//   one item at a time; o_ready is high only while idle, so the next item is taken only once
//   the current one has reached the output register. a step runs the cordic unit, which
//   runs one micro-rotation per cycle, twice, plus passes through the shared multiplier and
//   a seven-pass modulo-2pi reduction; a restart runs the reduction and the cordic once.
// Reset
//   synchronous active-low i_rst_n loads the config defaults and the initial state.
// Stalls
//   a finished result waits in the output register; the next item is taken meanwhile and
//   is held in its last stage until the output register frees up.

module pendulum_euler_step_unit
    import pes_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
    parameter int PIXEL_BITS        = PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_restart,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [30:0]    o_angle,
    output logic signed [31:0]    o_rate,
    output logic signed [15:0]    o_bob_x,
    output logic signed [15:0]    o_bob_y,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic signed [SAT_W-1:0] PX_MAX = SAT_W'((1 <<< (PIXEL_BITS - 1)) - 1);
    localparam logic signed [SAT_W-1:0] PX_MIN = -PX_MAX - SAT_W'(1);

    // configuration
    logic        [30:0] r_gain;
    logic        [31:0] r_step;
    logic signed [30:0] r_init_angle;
    logic signed [31:0] r_init_rate;
    logic        [15:0] r_arm;
    logic signed [15:0] r_pivot_x;
    logic signed [15:0] r_pivot_y;

    // sequencer and datapath
    t_state             r_state, n_state;
    logic signed [30:0] r_angle, n_angle;
    logic signed [31:0] r_rate, n_rate;
    logic signed [31:0] r_nrate, n_nrate;
    logic        [38:0] r_k, n_k;
    logic        [63:0] r_acc, n_acc;
    logic               r_uneg, n_uneg;
    logic        [37:0] r_mag, n_mag;
    logic        [2:0]  r_j, n_j;
    logic signed [15:0] r_bx, n_bx;
    logic signed [15:0] r_by, n_by;

    // output register
    logic               r_ovalid, n_ovalid;
    logic signed [30:0] r_oangle, n_oangle;
    logic signed [31:0] r_orate, n_orate;
    logic signed [15:0] r_obx, n_obx;
    logic signed [15:0] r_oby, n_oby;

    // shared units
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic                      c_start;
    t_trig                     trig;

    // combinational helpers
    logic        [TRIG_W-1:0] sin_abs;
    logic        [27:0]       sin_m;
    logic        [32:0]       rate_neg;
    logic        [31:0]       rate_abs;
    logic        [63:0]       acc_sum;
    logic        [39:0]       dmag;
    logic signed [41:0]       nr_wide;
    logic        [35:0]       dang;
    logic signed [37:0]       v_sum;
    logic signed [37:0]       angle_src;
    logic signed [38:0]       u_val;
    logic        [38:0]       u_neg_val;
    logic        [37:0]       red_sub;
    logic        [37:0]       rem;
    logic signed [31:0]       angle_fix;
    logic signed [2*MUL_W-1:0] p_rnd;
    logic signed [17:0]       px_off;
    logic signed [15:0]       px_pivot;
    logic signed [SAT_W-1:0]  px_sum;
    logic signed [SAT_W-1:0]  px_sat;
    logic                     in_xfer;
    logic                     out_free;

    pes_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    pes_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_angle (r_angle),
        .o_trig  (trig)
    );

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_valid && o_ready;
    assign out_free    = !r_ovalid || i_ready;

    // arithmetic shared by several states
    always_comb begin
        sin_abs   = trig.sin_v[TRIG_W-1] ? TRIG_W'(-trig.sin_v) : TRIG_W'(trig.sin_v);
        sin_m     = sin_abs[33:6];
        rate_neg  = -{r_rate[31], r_rate};
        rate_abs  = r_rate[31] ? rate_neg[31:0] : r_rate;

        acc_sum   = r_acc + {mul_p[43:0], 20'd0};
        dmag      = acc_sum[63:24];
        if (trig.sin_v[TRIG_W-1])
            nr_wide = 42'(r_rate) + $signed({2'b00, dmag});
        else
            nr_wide = 42'(r_rate) - $signed({2'b00, dmag});

        dang      = mul_p[63:28];
        if (r_rate[31])
            v_sum = 38'(r_angle) - $signed({2'b00, dang});
        else
            v_sum = 38'(r_angle) + $signed({2'b00, dang});
        angle_src = (r_state == ST_IDLE) ? 38'(r_init_angle) : v_sum;
        u_val     = 39'(PI_Q) - 39'(angle_src);
        u_neg_val = -u_val;

        red_sub   = two_pi_shl(r_j);
        rem       = (r_uneg && (r_mag != '0)) ? (TWO_PI_Q - r_mag) : r_mag;
        angle_fix = 32'(PI_Q) - $signed(rem[31:0]);

        // arm * trig is q12.4 times q2.30, round half up to whole pixels
        p_rnd     = mul_p + (68'sd1 <<< 33);
        px_off    = p_rnd[51:34];
        px_pivot  = (r_state == ST_MUL_Y) ? r_pivot_x : r_pivot_y;
        px_sum    = SAT_W'(px_pivot) + SAT_W'(px_off);
        if (px_sum > PX_MAX)
            px_sat = PX_MAX;
        else if (px_sum < PX_MIN)
            px_sat = PX_MIN;
        else
            px_sat = px_sum;
    end

    // sequencer: next state, unit controls and datapath updates
    always_comb begin
        n_state  = r_state;
        n_angle  = r_angle;
        n_rate   = r_rate;
        n_nrate  = r_nrate;
        n_k      = r_k;
        n_acc    = r_acc;
        n_uneg   = r_uneg;
        n_mag    = r_mag;
        n_j      = r_j;
        n_bx     = r_bx;
        n_by     = r_by;
        n_ovalid = r_ovalid && !i_ready;
        n_oangle = r_oangle;
        n_orate  = r_orate;
        n_obx    = r_obx;
        n_oby    = r_oby;
        mul_a    = '0;
        mul_b    = '0;
        c_start  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_restart) begin
                        n_nrate = r_init_rate;
                        n_uneg  = u_val[38];
                        n_mag   = u_val[38] ? u_neg_val[37:0] : u_val[37:0];
                        n_j     = REDUCE_TOP;
                        n_state = ST_REDUCE;
                    end else begin
                        n_state = ST_OLD_GO;
                    end
                end
            end
            ST_OLD_GO: begin
                c_start = 1'b1;
                n_state = ST_OLD_WAIT;
            end
            ST_OLD_WAIT: begin
                if (trig.done)
                    n_state = ST_MUL_K;
            end
            ST_MUL_K: begin
                mul_a   = MUL_W'(r_step);
                mul_b   = MUL_W'(r_gain);
                n_state = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                // k is q15.24, split so each partial product stays narrow
                n_k     = mul_p[62:24];
                mul_a   = MUL_W'(mul_p[43:24]);
                mul_b   = MUL_W'(sin_m);
                n_state = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                n_acc   = mul_p[63:0];
                mul_a   = MUL_W'(r_k[38:20]);
                mul_b   = MUL_W'(sin_m);
                n_state = ST_RATE;
            end
            ST_RATE: begin
                if (nr_wide > 42'sd2147483647)
                    n_nrate = 32'sh7FFFFFFF;
                else if (nr_wide < -42'sd2147483648)
                    n_nrate = 32'sh80000000;
                else
                    n_nrate = nr_wide[31:0];
                mul_a   = MUL_W'(r_step);
                mul_b   = MUL_W'(rate_abs);
                n_state = ST_ANGLE;
            end
            ST_ANGLE: begin
                n_uneg  = u_val[38];
                n_mag   = u_val[38] ? u_neg_val[37:0] : u_val[37:0];
                n_j     = REDUCE_TOP;
                n_state = ST_REDUCE;
            end
            ST_REDUCE: begin
                // restoring reduction of |pi - angle| modulo 2pi
                if (r_mag >= red_sub)
                    n_mag = r_mag - red_sub;
                if (r_j == '0)
                    n_state = ST_FIX;
                else
                    n_j = r_j - 3'd1;
            end
            ST_FIX: begin
                n_angle = angle_fix[30:0];
                n_rate  = r_nrate;
                n_state = ST_NEW_GO;
            end
            ST_NEW_GO: begin
                c_start = 1'b1;
                n_state = ST_NEW_WAIT;
            end
            ST_NEW_WAIT: begin
                if (trig.done) begin
                    mul_a   = MUL_W'(r_arm);
                    mul_b   = MUL_W'(trig.sin_v);
                    n_state = ST_MUL_Y;
                end
            end
            ST_MUL_Y: begin
                n_bx    = px_sat[15:0];
                mul_a   = MUL_W'(r_arm);
                mul_b   = MUL_W'(trig.cos_v);
                n_state = ST_BOB_Y;
            end
            ST_BOB_Y: begin
                n_by    = px_sat[15:0];
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oangle = r_angle;
                    n_orate  = r_rate;
                    n_obx    = r_bx;
                    n_oby    = r_by;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_angle  <= INIT_ANGLE_RST;
            r_rate   <= INIT_RATE_RST;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_angle  <= n_angle;
            r_rate   <= n_rate;
        end
        r_nrate  <= n_nrate;
        r_k      <= n_k;
        r_acc    <= n_acc;
        r_uneg   <= n_uneg;
        r_mag    <= n_mag;
        r_j      <= n_j;
        r_bx     <= n_bx;
        r_by     <= n_by;
        r_oangle <= n_oangle;
        r_orate  <= n_orate;
        r_obx    <= n_obx;
        r_oby    <= n_oby;
    end

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= GAIN_RST;
            r_step       <= STEP_RST;
            r_init_angle <= INIT_ANGLE_RST;
            r_init_rate  <= INIT_RATE_RST;
            r_arm        <= ARM_RST;
            r_pivot_x    <= PIVOT_X_RST;
            r_pivot_y    <= PIVOT_Y_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GAIN:       r_gain       <= i_cfg_data[30:0];
                CFG_STEP:       r_step       <= i_cfg_data;
                CFG_INIT_ANGLE: r_init_angle <= i_cfg_data[30:0];
                CFG_INIT_RATE:  r_init_rate  <= i_cfg_data;
                CFG_ARM:        r_arm        <= i_cfg_data[15:0];
                CFG_PIVOT_X:    r_pivot_x    <= i_cfg_data[15:0];
                CFG_PIVOT_Y:    r_pivot_y    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_angle = r_oangle;
    assign o_rate  = r_orate;
    assign o_bob_x = r_obx;
    assign o_bob_y = r_oby;

endmodule

FILE: test/pendulum_step_checker.sv
// checker for the pendulum euler step unit: predicts each result from the item and
// register transfers it sees, and compares the outputs field by field; uses pes_pkg
`timescale 1ns / 1ps

module pendulum_step_checker
    import pes_pkg::*;
#(
    parameter int ITERATIONS = CORDIC_ITERATIONS_DEF,
    parameter int PIX_BITS   = PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_restart,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [30:0]           i_angle,
    input  logic [31:0]           i_rate,
    input  logic [15:0]           i_bob_x,
    input  logic [15:0]           i_bob_y,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_failures,
    output int                    o_outstanding
);

    localparam longint HALF_TURN    = 843314856;
    localparam longint FULL_TURN    = 2 * HALF_TURN;
    localparam longint QUARTER_TURN = 421657428;
    localparam longint UNIT_GAIN    = 652032874;
    localparam int     REPORT_CAP   = 60;

    typedef struct packed {
        logic [30:0] angle;
        logic [31:0] rate;
        logic [15:0] bob_x;
        logic [15:0] bob_y;
    } t_pose;

    t_pose       expected_poses[$];
    longint      arctan_q30[32];
    int          report_count = 0;

    // register copy
    logic [30:0] gain_q16;
    logic [31:0] dt_q32;
    longint      init_angle_q28;
    longint      init_rate_q24;
    logic [15:0] arm_q4;
    longint      pivot_x_px;
    longint      pivot_y_px;

    // pendulum state
    longint      angle_q28;
    longint      rate_q24;

    initial begin
        arctan_q30[0] = 843314857;
        arctan_q30[1] = 497837829;
        arctan_q30[2] = 263043837;
        arctan_q30[3] = 133525159;
        arctan_q30[4] = 67021687;
        arctan_q30[5] = 33543516;
        arctan_q30[6] = 16775851;
        arctan_q30[7] = 8388437;
        arctan_q30[8] = 4194283;
        arctan_q30[9] = 2097149;
        for (int i = 10; i < 31; i++) begin
            arctan_q30[i] = longint'(1) << (30 - i);
        end
        arctan_q30[31] = 0;
    end

    // reduce into (-pi, pi]
    function automatic longint fold_angle(input longint v);
        longint u;
        u = (HALF_TURN - v) % FULL_TURN;
        if (u < 0) begin
            u += FULL_TURN;
        end
        return HALF_TURN - u;
    endfunction

    function automatic void spin_cordic(input longint ang, output longint sin_q30,
                                        output longint cos_q30);
        longint x, y, z, dx, dy;
        logic   flip;
        x    = UNIT_GAIN;
        y    = 0;
        flip = 1'b0;
        // outer half-planes rotate by pi and negate
        if (ang > QUARTER_TURN) begin
            ang  -= HALF_TURN;
            flip = 1'b1;
        end else if (ang < -QUARTER_TURN) begin
            ang  += HALF_TURN;
            flip = 1'b1;
        end
        z = ang * 4;
        for (int i = 0; i < ITERATIONS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= arctan_q30[i];
            end else begin
                x += dx;
                y -= dy;
                z += arctan_q30[i];
            end
        end
        sin_q30 = flip ? -y : y;
        cos_q30 = flip ? -x : x;
    endfunction

    function automatic longint bob_pixel(input longint pivot, input longint trig);
        longint lim, arm, v;
        lim = longint'(1) << (PIX_BITS - 1);
        arm = arm_q4;
        v   = pivot + ((arm * trig + (longint'(1) << 33)) >>> 34);
        if (v > lim - 1) begin
            v = lim - 1;
        end
        if (v < -lim) begin
            v = -lim;
        end
        return v;
    endfunction

    function automatic t_pose advance_pendulum(input logic reload);
        longint          s, c, nr, dl, mag, bx, by;
        longint unsigned k, m, dmag, amag, d;
        t_pose           p;
        if (reload) begin
            angle_q28 = fold_angle(init_angle_q28);
            rate_q24  = init_rate_q24;
        end else begin
            spin_cordic(angle_q28, s, c);
            k    = (64'(dt_q32) * 64'(gain_q16)) >> 24;
            mag  = (s < 0) ? -s : s;
            m    = mag;
            m    = m >> 6;
            dmag = (k * m) >> 24;
            nr   = (s < 0) ? rate_q24 + signed'(dmag) : rate_q24 - signed'(dmag);
            if (nr > 64'sd2147483647) begin
                nr = 64'sd2147483647;
            end
            if (nr < -64'sd2147483648) begin
                nr = -64'sd2147483648;
            end
            // angle moves with the old rate
            mag  = (rate_q24 < 0) ? -rate_q24 : rate_q24;
            amag = mag;
            d    = (64'(dt_q32) * amag) >> 28;
            dl   = signed'(d);
            if (rate_q24 < 0) begin
                dl = -dl;
            end
            angle_q28 = fold_angle(angle_q28 + dl);
            rate_q24  = nr;
        end
        spin_cordic(angle_q28, s, c);
        bx      = bob_pixel(pivot_x_px, s);
        by      = bob_pixel(pivot_y_px, c);
        p.angle = angle_q28[30:0];
        p.rate  = rate_q24[31:0];
        p.bob_x = bx[15:0];
        p.bob_y = by[15:0];
        return p;
    endfunction

    function automatic bit field_bad(input string label, input logic [31:0] want,
                                     input logic [31:0] got);
        if (want === got) begin
            return 1'b0;
        end
        if (report_count < REPORT_CAP) begin
            $display("%0t ns: %s expected %h, actual %h", $time, label, want, got);
            report_count++;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pose want;
        int    miss;
        miss = 0;
        if (!i_rst_n) begin
            gain_q16       = 31'd6422528;
            dt_q32         = 32'd429497;
            init_angle_q28 = 168662971;
            init_rate_q24  = 0;
            arm_q4         = 16'd6047;
            pivot_x_px     = 400;
            pivot_y_px     = 0;
            angle_q28      = fold_angle(init_angle_q28);
            rate_q24       = init_rate_q24;
            expected_poses.delete();
            o_failures    <= 0;
            o_outstanding <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_poses.size() == 0) begin
                    if (report_count < REPORT_CAP) begin
                        $display("%0t ns: result transfer with nothing expected, actual %h %h",
                                 $time, i_angle, i_rate);
                        report_count++;
                    end
                    miss = 1;
                end else begin
                    want = expected_poses.pop_front();
                    if (field_bad("angle", want.angle, i_angle) |
                        field_bad("rate", want.rate, i_rate) |
                        field_bad("bob_x", want.bob_x, i_bob_x) |
                        field_bad("bob_y", want.bob_y, i_bob_y)) begin
                        miss = 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GAIN:       gain_q16       = i_cfg_data[30:0];
                    CFG_STEP:       dt_q32         = i_cfg_data;
                    CFG_INIT_ANGLE: init_angle_q28 = $signed(i_cfg_data[30:0]);
                    CFG_INIT_RATE:  init_rate_q24  = $signed(i_cfg_data);
                    CFG_ARM:        arm_q4         = i_cfg_data[15:0];
                    CFG_PIVOT_X:    pivot_x_px     = $signed(i_cfg_data[15:0]);
                    CFG_PIVOT_Y:    pivot_y_px     = $signed(i_cfg_data[15:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_poses.push_back(advance_pendulum(i_restart));
            end
            o_failures    <= o_failures + miss;
            o_outstanding <= expected_poses.size();
        end
    end

endmodule

FILE: test/pendulum_euler_step_unit_tb.sv
// testbench top for the pendulum euler step unit: clock, reset, stimulus and verdict
// depends on pes_pkg, pendulum_euler_step_unit and pendulum_step_checker
`timescale 1ns / 1ps

module pendulum_euler_step_unit_tb;
    import pes_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 650;
    localparam int SETTLE_CYCLES  = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_restart;
    logic                  o_valid;
    logic                  i_ready;
    logic signed [30:0]    o_angle;
    logic signed [31:0]    o_rate;
    logic signed [15:0]    o_bob_x;
    logic signed [15:0]    o_bob_y;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int   failures;
    int   outstanding;
    int   quiet_cycles = 0;
    int   stall_left   = 0;
    logic steady;
    int   items_sent   = 0;
    int   reloads      = 0;
    int   reg_writes   = 0;
    int   settings     = 1;

    always #5 i_clk = ~i_clk;

    pendulum_euler_step_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_angle     (o_angle),
        .o_rate      (o_rate),
        .o_bob_x     (o_bob_x),
        .o_bob_y     (o_bob_y),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pendulum_step_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_restart     (i_restart),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_angle       (o_angle),
        .i_rate        (o_rate),
        .i_bob_x       (o_bob_x),
        .i_bob_y       (o_bob_y),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    // result side: occasional stall runs, the longest enough to cover a whole step
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (!steady && $urandom_range(9999) < 15) begin
            stall_left <= $urandom_range(89);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(input logic reload, input int gap);
        i_valid   <= 1'b1;
        i_restart <= reload;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (reload) begin
            reloads++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // registers change only once the unit has handed back every result
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        logic [31:0]          probes [0:5];
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          data;
        int                   pick;
        int                   sent;
        int                   seg;
        int                   gap;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_restart   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_GAIN;
        i_cfg_data  <= '0;
        steady      <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // power-on values: step from the reset state, then reload
        send_item(1'b0, 0);
        send_item(1'b0, 3);
        send_item(1'b0, 0);
        send_item(1'b1, 0);
        drain_results();

        // every field at its top value but pivot y, which takes its bottom; the angle is out of range and wraps on load
        write_reg(CFG_GAIN, 32'hFFFF_FFFF);
        write_reg(CFG_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_INIT_ANGLE, 32'h3FFF_FFFF);
        write_reg(CFG_INIT_RATE, 32'h7FFF_FFFF);
        write_reg(CFG_ARM, 32'h0000_FFFF);
        write_reg(CFG_PIVOT_X, 32'h0000_7FFF);
        write_reg(CFG_PIVOT_Y, 32'h0000_8000);
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        settings++;
        send_item(1'b1, 0);
        send_item(1'b0, 0);
        send_item(1'b0, 5);
        send_item(1'b0, 0);
        drain_results();

        // bottom of the angle and rate fields, rate pinned at the negative limit
        write_reg(CFG_INIT_ANGLE, 32'h4000_0000);
        write_reg(CFG_INIT_RATE, 32'h8000_0000);
        write_reg(CFG_PIVOT_X, 32'h0000_8000);
        write_reg(CFG_PIVOT_Y, 32'h0000_7FFF);
        settings++;
        send_item(1'b1, 0);
        send_item(1'b0, 0);
        send_item(1'b0, 0);
        drain_results();

        // all-zero gains, step and arm: nothing moves
        write_reg(CFG_GAIN, 32'h0);
        write_reg(CFG_STEP, 32'h0);
        write_reg(CFG_ARM, 32'h0);
        write_reg(CFG_PIVOT_X, 32'h0);
        write_reg(CFG_PIVOT_Y, 32'h0);
        settings++;
        send_item(1'b1, 0);
        send_item(1'b0, 0);
        drain_results();

        // quadrant edges of the cordic and both ends of the wrap interval
        probes = '{32'd421657428, 32'd421657429, 32'(-421657429),
                   32'd843314856, 32'(-843314856), 32'd0};
        write_reg(CFG_ARM, 32'h0000_FFFF);
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_INIT_ANGLE, probes[p]);
            settings++;
            send_item(1'b1, 0);
            drain_results();
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            for (int r = CFG_GAIN; r <= CFG_PIVOT_Y; r++) begin
                reg_idx = CFG_IDX_W'(r);
                pick    = $urandom_range(9);
                if ($urandom_range(99) < 60) begin
                    case (reg_idx)
                        CFG_GAIN:
                            data = (pick == 0) ? 32'h0 : (pick == 1) ? 32'h7FFF_FFFF :
                                   (pick == 2) ? $urandom : $urandom_range(0, 100 << 16);
                        CFG_STEP:
                            data = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF :
                                   (pick == 2) ? $urandom : $urandom_range(0, 32'd67108864);
                        CFG_INIT_ANGLE:
                            data = (pick == 0) ? 32'h4000_0000 : (pick == 1) ? 32'h3FFF_FFFF :
                                   (pick == 2) ? $urandom :
                                   $urandom_range(0, 32'd1686629712) - 32'd843314856;
                        CFG_INIT_RATE:
                            data = (pick == 0) ? 32'h8000_0000 : (pick == 1) ? 32'h7FFF_FFFF :
                                   (pick == 2) ? $urandom :
                                   $urandom_range(0, 32'd671088640) - 32'd335544320;
                        CFG_ARM:
                            data = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF :
                                   $urandom;
                        default:
                            data = (pick == 0) ? 32'h8000 : (pick == 1) ? 32'h7FFF :
                                   (pick == 2) ? $urandom : $urandom_range(0, 1000);
                    endcase
                    write_reg(reg_idx, data);
                end
            end
            if ($urandom_range(9) == 0) begin
                write_reg(CFG_SPARE, $urandom);
            end
            settings++;

            // mostly long stepping runs from a fresh reload
            seg = $urandom_range(10, 70);
            for (int j = 0; j < seg && sent < RANDOM_ITEMS; j++) begin
                steady <= (sent >= 250 && sent < 400);
                gap = 0;
                if (!(sent >= 250 && sent < 400) && $urandom_range(99) < 30) begin
                    gap = $urandom_range(1, 30);
                end
                if (j == 0) begin
                    send_item($urandom_range(99) < 75, gap);
                end else begin
                    send_item($urandom_range(99) < 6, gap);
                end
                sent++;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d items, %0d of them reloads, across %0d register settings",
                 items_sent, reloads, settings);
        $display("%0d register writes, field extremes and out-of-range angles among them",
                 reg_writes);
        if (failures == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
